FILE: src/rhaf_pkg.sv
// Package for the recent hash age filter: widths, codes, states, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rhaf_pkg;
   localparam int RingDepth     = 4096;
   localparam int RingAw        = $clog2(RingDepth);
   localparam int TableLogSlots = 13;
   localparam int TableSize     = 1 << TableLogSlots;
   localparam int TableAw       = TableLogSlots;
   localparam int CsrAw         = 3;

   localparam logic [15:0] MaxAgeReset = 16'd151;

   typedef logic [TableAw-1:0] tidx_type;
   typedef logic [255:0]       key_type;

   typedef enum logic [1:0] {
      ACT_CHECK  = 2'd0,
      ACT_BANK   = 2'd1,
      ACT_ROOTED = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      VERDICT_PASS    = 2'd0,
      VERDICT_EXPIRED = 2'd1,
      VERDICT_DROPPED = 2'd2
   } verdict_type;

   localparam logic [CsrAw-1:0] CSR_MAX_AGE = 3'd0;

   typedef enum logic [13:0] {
      ST_CLEAR   = 14'b00000000000001,
      ST_IDLE    = 14'b00000000000010,
      ST_RRD     = 14'b00000000000100,
      ST_RWAIT   = 14'b00000000001000,
      ST_FPROBE  = 14'b00000000010000,
      ST_FCMP    = 14'b00000000100000,
      ST_RMPROBE = 14'b00000001000000,
      ST_RMCMP   = 14'b00000010000000,
      ST_RMDONE  = 14'b00000100000000,
      ST_INS     = 14'b00001000000000,
      ST_INSCMP  = 14'b00010000000000,
      ST_CHK     = 14'b00100000000000,
      ST_CHKCMP  = 14'b01000000000000,
      ST_OUT     = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic     rd;
      tidx_type rd_addr;
      logic     wr;
      tidx_type wr_addr;
      logic     wr_used;
      logic     wr_data_sel_hold;
   } tbl_cmd_type;

   function automatic tidx_type home_of(input key_type k);
      return k[TableAw-1:0];
   endfunction
endpackage
`default_nettype wire

FILE: src/rhaf_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rhaf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] hash_word0;
   logic [63:0] hash_word1;
   logic [63:0] hash_word2;
   logic [63:0] hash_word3;
   logic [63:0] bank_slot;
   logic        needs_tables;
   modport source (output valid, action, hash_word0, hash_word1, hash_word2, hash_word3,
                   bank_slot, needs_tables, input ready);
   modport sink (input valid, action, hash_word0, hash_word1, hash_word2, hash_word3,
                 bank_slot, needs_tables, output ready);
endinterface

interface rhaf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [63:0] lookup_slot;
   modport source (output valid, verdict, lookup_slot, input ready);
   modport sink (input valid, verdict, lookup_slot, output ready);
endinterface
`default_nettype wire

FILE: src/rhaf_table.sv
// Hash table storage: key, slot and used-bit memories, registered reads.
// Depends on rhaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhaf_table (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         clr,
   input  wire rhaf_pkg::tidx_type     clr_addr,
   input  wire rhaf_pkg::tbl_cmd_type  cmd,
   input  wire rhaf_pkg::key_type      wr_key,
   input  wire [63:0]                  wr_slot,
   output rhaf_pkg::key_type           rd_key,
   output logic [63:0]                 rd_slot,
   output logic                        rd_used
);
   import rhaf_pkg::*;
   key_type     key_mem  [TableSize];
   logic [63:0] slot_mem [TableSize];
   logic        used_mem [TableSize];
   key_type     key_ff;
   logic [63:0] slot_ff;
   logic        used_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         key_mem[cmd.wr_addr]  <= wr_key;
         slot_mem[cmd.wr_addr] <= wr_slot;
      end
      if (clr) used_mem[clr_addr] <= 1'b0;
      else if (cmd.wr || cmd.wr_data_sel_hold) used_mem[cmd.wr_addr] <= cmd.wr_used;
      if (cmd.rd) begin
         key_ff  <= key_mem[cmd.rd_addr];
         slot_ff <= slot_mem[cmd.rd_addr];
         used_ff <= used_mem[cmd.rd_addr];
      end
      if (reset) used_ff <= 1'b0;
   end
   assign rd_key  = key_ff;
   assign rd_slot = slot_ff;
   assign rd_used = used_ff;
endmodule
`default_nettype wire

FILE: src/rhaf_ring.sv
// Ring of recent hashes, one 256-bit entry per position, registered read.
// Depends on rhaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhaf_ring (
   input  wire                       clock,
   input  wire                       wr,
   input  wire                       rd,
   input  wire [rhaf_pkg::RingAw-1:0] addr,
   input  wire rhaf_pkg::key_type    wr_key,
   output rhaf_pkg::key_type         rd_key
);
   import rhaf_pkg::*;
   key_type mem [RingDepth];
   key_type rd_ff;
   always_ff @(posedge clock) begin
      if (wr) mem[addr] <= wr_key;
      if (rd) rd_ff <= mem[addr];
   end
   assign rd_key = rd_ff;
endmodule
`default_nettype wire

FILE: src/recent_hash_age_filter_unit.sv
// Recent hash age filter top level: sequencer, shared probe comparator, ring and table
// memories, APB register. Depends on rhaf_pkg, rhaf_if, rhaf_ring, rhaf_table.
// Check: table probes (CHK/CHKCMP) until hit, empty slot or wrap, then OUT; zero hash: OUT
// at once. Bank: ring read, find and remove of the evicted entry unless zero, then insert.
// Throughput: one request at a time; ready only in idle with no result waiting.
// Reset: synchronous; a clearing pass (used bits and ring) follows and takes no request.
`timescale 1ns / 1ps
`default_nettype none
module recent_hash_age_filter_unit (
   input  wire                         clock,
   input  wire                         reset,
   rhaf_req_if.sink                    req,
   rhaf_rsp_if.source                  rsp,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire [rhaf_pkg::CsrAw-1:0]   paddr,
   input  wire [31:0]                  pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import rhaf_pkg::*;

   state_type       state_ff, state_in;
   logic [15:0]     max_age_ff;
   logic [63:0]     cur_slot_ff, cur_slot_in;
   logic            root_ff, root_in;
   logic [RingAw-1:0] pos_ff, pos_in;
   logic [TableAw:0] clr_ff, clr_in;
   key_type         key_ff, key_in;
   logic [63:0]     slot_ff, slot_in;
   logic            needs_ff, needs_in;
   key_type         old_ff, old_in;
   tidx_type        e_ff, e_in;
   tidx_type        hole_ff, hole_in;
   logic [TableAw:0] n_ff, n_in;
   logic [1:0]      verdict_ff, verdict_in;
   logic [63:0]     ref_ff, ref_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RingAw:0] rclr_ff, rclr_in;

   tbl_cmd_type     cmd;
   key_type         t_key, wkey, ring_rd, ring_wkey;
   logic [63:0]     t_slot, wslot;
   logic            t_used, ring_wr, ring_rd_en;
   logic [RingAw-1:0] ring_addr;
   logic            key_eq;
   tidx_type        home_s;
   logic [64:0]     age_sum;
   logic            accept;

   rhaf_ring u_ring (.clock, .wr(ring_wr), .rd(ring_rd_en), .addr(ring_addr),
                     .wr_key(ring_wkey), .rd_key(ring_rd));
   rhaf_table u_table (.clock, .reset, .clr(state_ff == ST_CLEAR),
                       .clr_addr(clr_ff[TableAw-1:0]), .cmd, .wr_key(wkey),
                       .wr_slot(wslot), .rd_key(t_key), .rd_slot(t_slot), .rd_used(t_used));

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_MAX_AGE) ? {16'd0, max_age_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) max_age_ff <= MaxAgeReset;
      else if (psel && penable && pwrite && paddr == CSR_MAX_AGE) max_age_ff <= pwdata[15:0];
   end

   assign req.ready         = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept            = req.valid && req.ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.verdict       = verdict_ff;
   assign rsp.lookup_slot   = ref_ff;

   // shared probe comparator
   always_comb begin
      key_eq = (t_key == ((state_ff == ST_FCMP) ? old_ff : key_ff));
      home_s = home_of(t_key);
      age_sum = {1'b0, t_slot} + {49'd0, max_age_ff};
   end

   always_comb begin
      state_in = state_ff; cur_slot_in = cur_slot_ff; root_in = root_ff; pos_in = pos_ff;
      clr_in = clr_ff; key_in = key_ff; slot_in = slot_ff; needs_in = needs_ff;
      old_in = old_ff; e_in = e_ff; hole_in = hole_ff; n_in = n_ff;
      verdict_in = verdict_ff; ref_in = ref_ff; rclr_in = rclr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      cmd = '0; wkey = key_ff; wslot = slot_ff;
      ring_wr = 1'b0; ring_rd_en = 1'b0; ring_addr = pos_ff; ring_wkey = key_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ring_wr = !rclr_ff[RingAw]; ring_addr = rclr_ff[RingAw-1:0]; ring_wkey = '0;
            if (!rclr_ff[RingAw]) rclr_in = rclr_ff + 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (TableAw+1)'(TableSize - 1) && rclr_ff[RingAw])
               state_in = ST_IDLE;
            else if (clr_ff == (TableAw+1)'(TableSize - 1)) clr_in = clr_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               key_in = {req.hash_word3, req.hash_word2, req.hash_word1, req.hash_word0};
               slot_in = req.bank_slot; needs_in = req.needs_tables;
               e_in = home_of({req.hash_word3, req.hash_word2, req.hash_word1,
                               req.hash_word0});
               n_in = '0;
               unique case (action_type'(req.action))
                  ACT_CHECK: begin
                     if (key_in == '0) begin
                        verdict_in = (req.needs_tables && !root_ff) ?
                                     VERDICT_DROPPED : VERDICT_PASS;
                        ref_in = cur_slot_ff; state_in = ST_OUT;
                     end else state_in = ST_CHK;
                  end
                  ACT_BANK:   state_in = ST_RRD;
                  ACT_ROOTED: root_in = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_RRD: begin
            ring_rd_en = 1'b1; state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            old_in = ring_rd; e_in = home_of(ring_rd); n_in = '0;
            ring_wr = 1'b1;
            state_in = (ring_rd == '0) ? ST_INS : ST_FPROBE;
            if (ring_rd == '0) e_in = home_of(key_ff);
            pos_in = (pos_ff == RingAw'(RingDepth - 1)) ? '0 : pos_ff + 1'b1;
         end
         ST_FPROBE: begin
            cmd.rd = 1'b1; cmd.rd_addr = e_ff; state_in = ST_FCMP;
         end
         ST_FCMP: begin
            if (!t_used || n_ff[TableAw]) begin
               state_in = ST_INS; e_in = home_of(key_ff); n_in = '0;
            end else if (key_eq) begin
               hole_in = e_ff; e_in = e_ff + 1'b1; n_in = '0; state_in = ST_RMPROBE;
            end else begin
               e_in = e_ff + 1'b1; n_in = n_ff + 1'b1; state_in = ST_FPROBE;
            end
         end
         ST_RMPROBE: begin
            cmd.rd = 1'b1; cmd.rd_addr = e_ff; state_in = ST_RMCMP;
         end
         ST_RMCMP: begin
            if (!t_used || e_ff == hole_ff || n_ff[TableAw]) state_in = ST_RMDONE;
            else begin
               if ((TableAw'(e_ff - home_s)) >= (TableAw'(e_ff - hole_ff))) begin
                  cmd.wr = 1'b1; cmd.wr_addr = hole_ff; cmd.wr_used = 1'b1;
                  wkey = t_key; wslot = t_slot; hole_in = e_ff;
               end
               e_in = e_ff + 1'b1; n_in = n_ff + 1'b1; state_in = ST_RMPROBE;
            end
         end
         ST_RMDONE: begin
            cmd.wr_data_sel_hold = 1'b1; cmd.wr_addr = hole_ff; cmd.wr_used = 1'b0;
            e_in = home_of(key_ff); n_in = '0; state_in = ST_INS;
         end
         ST_INS: begin
            if (key_ff == '0) begin
               cur_slot_in = slot_ff; state_in = ST_IDLE;
            end else begin
               cmd.rd = 1'b1; cmd.rd_addr = e_ff; state_in = ST_INSCMP;
            end
         end
         ST_INSCMP: begin
            if (n_ff[TableAw]) begin
               cur_slot_in = slot_ff; state_in = ST_IDLE;
            end else if (!t_used) begin
               cmd.wr = 1'b1; cmd.wr_addr = e_ff; cmd.wr_used = 1'b1;
               cur_slot_in = slot_ff; state_in = ST_IDLE;
            end else if (key_eq) begin
               cmd.wr = 1'b1; cmd.wr_addr = e_ff; cmd.wr_used = 1'b1;
               cur_slot_in = slot_ff; state_in = ST_IDLE;
            end else begin
               e_in = e_ff + 1'b1; n_in = n_ff + 1'b1; state_in = ST_INS;
            end
         end
         ST_CHK: begin
            cmd.rd = 1'b1; cmd.rd_addr = e_ff; state_in = ST_CHKCMP;
         end
         ST_CHKCMP: begin
            if (!t_used || n_ff[TableAw] || key_eq) begin
               ref_in = cur_slot_ff; verdict_in = VERDICT_PASS;
               if (t_used && !n_ff[TableAw] && key_eq) begin
                  ref_in = t_slot;
                  if ({1'b0, cur_slot_ff} > age_sum) verdict_in = VERDICT_EXPIRED;
               end
               if (verdict_in == VERDICT_PASS && needs_ff && !root_ff)
                  verdict_in = VERDICT_DROPPED;
               state_in = ST_OUT;
            end else begin
               e_in = e_ff + 1'b1; n_in = n_ff + 1'b1; state_in = ST_CHK;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; cur_slot_ff <= '0; root_ff <= 1'b0; pos_ff <= '0;
         clr_ff <= '0; rclr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cur_slot_ff <= cur_slot_in; root_ff <= root_in;
         pos_ff <= pos_in; clr_ff <= clr_in; rclr_ff <= rclr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in; slot_ff <= slot_in; needs_ff <= needs_in; old_ff <= old_in;
      e_ff <= e_in; hole_ff <= hole_in; n_ff <= n_in; verdict_ff <= verdict_in;
      ref_ff <= ref_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready outside idle");
   a_out_then_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> rsp.valid) else $error("result lost");
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.verdict != 2'd3)) else $error("bad verdict");
endmodule
`default_nettype wire
